// ----- hw/rtl/sha_pkg.sv -----
package sha_pkg;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_PAD,
        ST_ROUND,
        ST_ADD,
        ST_EMIT
    } state_t;

    typedef struct packed {
        logic load_byte;
        logic [7:0] load_value;
        logic count_byte;
        logic start_block;
        logic round_step;
        logic add_hash;
        logic reset_hash;
    } cmd_t;

    typedef struct packed {
        logic [5:0] fill;
        logic [63:0] bit_len;
    } status_t;

    localparam logic [7:0] PAD_BYTE = 8'h80;
    localparam logic [5:0] LEN_POS = 6'd56;

    localparam logic [31:0] INIT_HASH [8] = '{
        32'h6a09e667, 32'hbb67ae85, 32'h3c6ef372, 32'ha54ff53a,
        32'h510e527f, 32'h9b05688c, 32'h1f83d9ab, 32'h5be0cd19};

    localparam logic [31:0] ROUND_K [64] = '{
        32'h428a2f98, 32'h71374491, 32'hb5c0fbcf, 32'he9b5dba5, 32'h3956c25b, 32'h59f111f1,
        32'h923f82a4, 32'hab1c5ed5, 32'hd807aa98, 32'h12835b01, 32'h243185be, 32'h550c7dc3,
        32'h72be5d74, 32'h80deb1fe, 32'h9bdc06a7, 32'hc19bf174, 32'he49b69c1, 32'hefbe4786,
        32'h0fc19dc6, 32'h240ca1cc, 32'h2de92c6f, 32'h4a7484aa, 32'h5cb0a9dc, 32'h76f988da,
        32'h983e5152, 32'ha831c66d, 32'hb00327c8, 32'hbf597fc7, 32'hc6e00bf3, 32'hd5a79147,
        32'h06ca6351, 32'h14292967, 32'h27b70a85, 32'h2e1b2138, 32'h4d2c6dfc, 32'h53380d13,
        32'h650a7354, 32'h766a0abb, 32'h81c2c92e, 32'h92722c85, 32'ha2bfe8a1, 32'ha81a664b,
        32'hc24b8b70, 32'hc76c51a3, 32'hd192e819, 32'hd6990624, 32'hf40e3585, 32'h106aa070,
        32'h19a4c116, 32'h1e376c08, 32'h2748774c, 32'h34b0bcb5, 32'h391c0cb3, 32'h4ed8aa4a,
        32'h5b9cca4f, 32'h682e6ff3, 32'h748f82ee, 32'h78a5636f, 32'h84c87814, 32'h8cc70208,
        32'h90befffa, 32'ha4506ceb, 32'hbef9a3f7, 32'hc67178f2};

    function automatic logic [31:0] ror32(input logic [31:0] v, input int n);
        ror32 = (v >> n) | (v << (32 - n));
    endfunction

endpackage

// ----- hw/rtl/sha_if.sv -----
interface sha_in_if;
    logic valid;
    logic ready;
    logic kind;
    logic [7:0] data_byte;
    modport source (output valid, kind, data_byte, input ready);
    modport sink (input valid, kind, data_byte, output ready);
endinterface

interface sha_out_if;
    logic valid;
    logic ready;
    logic [31:0] digest_word;
    logic [2:0] word_index;
    logic last;
    modport source (output valid, digest_word, word_index, last, input ready);
    modport sink (input valid, digest_word, word_index, last, output ready);
endinterface

// ----- hw/rtl/sha256_stream_hasher_top.sv -----
// SHA-256 hasher over a byte stream.
// in_ch carries kind and data_byte: kind 0 appends data_byte, kind 1 ends the
// message. out_ch returns eight digest words, word_index 0 first, last on 7.
// Data bytes are taken one per cycle while in_ch.ready is high; every 64th
// byte starts a block compression (one round per cycle in the single round
// unit) followed by a hash update, during which in_ch.ready is low.
// A finish loads pad and length bytes one per cycle, runs one or two
// compressions, then presents the digest words one per cycle while
// out_ch.ready is high. A stalled receiver holds the current word; no new
// transaction is taken until the eighth word has gone.
// After the last word the hash state returns to the initial values, so the
// next message starts fresh. Reset (rst_n low) does the same at once.
module sha256_stream_hasher_top (
    input  logic clk,
    input  logic rst_n,
    sha_in_if.sink in_ch,
    sha_out_if.source out_ch
);
    sha_pkg::cmd_t cmd;
    sha_pkg::status_t status;
    logic [2:0] word_sel;
    logic [31:0] hash_word;

    sha_ctrl u_ctrl (
        .clk(clk), .rst_n(rst_n), .in_ch(in_ch), .out_ready(out_ch.ready),
        .out_valid(out_ch.valid), .word_sel(word_sel), .status(status), .cmd(cmd)
    );

    sha_datapath u_dp (
        .clk(clk), .rst_n(rst_n), .cmd(cmd), .word_sel(word_sel),
        .status(status), .hash_word(hash_word)
    );

    assign out_ch.digest_word = hash_word;
    assign out_ch.word_index = word_sel;
    assign out_ch.last = (word_sel == 3'd7);

    assert property (@(posedge clk) disable iff (!rst_n)
        out_ch.valid |-> !in_ch.ready)
        else $error("input taken while digest pending");
endmodule

// ----- hw/rtl/sha_datapath.sv -----
module sha_datapath (
    input  logic clk,
    input  logic rst_n,
    input  sha_pkg::cmd_t cmd,
    input  logic [2:0] word_sel,
    output sha_pkg::status_t status,
    output logic [31:0] hash_word
);
    // The 16-word window doubles as block buffer and message schedule.
    logic [31:0] w_reg [16];
    logic [31:0] w_next [16];
    logic [31:0] r_reg [8];
    logic [31:0] r_next [8];
    logic [31:0] h_reg [8];
    logic [31:0] h_next [8];
    logic [5:0] fill_reg;
    logic [5:0] fill_next;
    logic [5:0] round_reg;
    logic [5:0] round_next;
    logic [63:0] total_reg;
    logic [63:0] total_next;
    logic [31:0] s0, s1, t1, t2, w_new;

    assign status.fill = fill_reg;
    assign status.bit_len = {total_reg[60:0], 3'b000};
    assign hash_word = h_reg[word_sel];

    always_comb
    begin
        s0 = sha_pkg::ror32(w_reg[1], 7) ^ sha_pkg::ror32(w_reg[1], 18) ^ (w_reg[1] >> 3);
        s1 = sha_pkg::ror32(w_reg[14], 17) ^ sha_pkg::ror32(w_reg[14], 19)
            ^ (w_reg[14] >> 10);
        w_new = s1 + w_reg[9] + s0 + w_reg[0];
        t1 = r_reg[7] + (sha_pkg::ror32(r_reg[4], 6) ^ sha_pkg::ror32(r_reg[4], 11)
            ^ sha_pkg::ror32(r_reg[4], 25)) + ((r_reg[4] & r_reg[5]) ^ (~r_reg[4] & r_reg[6]))
            + sha_pkg::ROUND_K[round_reg] + w_reg[0];
        t2 = (sha_pkg::ror32(r_reg[0], 2) ^ sha_pkg::ror32(r_reg[0], 13)
            ^ sha_pkg::ror32(r_reg[0], 22))
            + ((r_reg[0] & r_reg[1]) ^ (r_reg[0] & r_reg[2]) ^ (r_reg[1] & r_reg[2]));
        w_next = w_reg;
        r_next = r_reg;
        h_next = h_reg;
        fill_next = fill_reg;
        round_next = round_reg;
        total_next = total_reg;
        if (cmd.count_byte)
            total_next = total_reg + 64'd1;
        if (cmd.load_byte)
        begin
            // shift bytes into the window; a full block lands in word order
            for (int i = 0; i < 15; i++)
                w_next[i] = {w_reg[i][23:0], w_reg[i + 1][31:24]};
            w_next[15] = {w_reg[15][23:0], cmd.load_value};
            fill_next = fill_reg + 6'd1;
        end
        if (cmd.start_block)
        begin
            r_next = h_reg;
            round_next = '0;
        end
        if (cmd.round_step)
        begin
            for (int i = 0; i < 15; i++)
                w_next[i] = w_reg[i + 1];
            w_next[15] = w_new;
            r_next[7] = r_reg[6];
            r_next[6] = r_reg[5];
            r_next[5] = r_reg[4];
            r_next[4] = r_reg[3] + t1;
            r_next[3] = r_reg[2];
            r_next[2] = r_reg[1];
            r_next[1] = r_reg[0];
            r_next[0] = t1 + t2;
            round_next = round_reg + 6'd1;
        end
        if (cmd.add_hash)
            for (int i = 0; i < 8; i++)
                h_next[i] = h_reg[i] + r_reg[i];
        if (cmd.reset_hash)
        begin
            h_next = sha_pkg::INIT_HASH;
            fill_next = '0;
            total_next = '0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            h_reg <= sha_pkg::INIT_HASH;
            fill_reg <= '0;
            total_reg <= '0;
            round_reg <= '0;
        end
        else
        begin
            h_reg <= h_next;
            fill_reg <= fill_next;
            total_reg <= total_next;
            round_reg <= round_next;
        end
    end

    always_ff @(posedge clk)
    begin
        w_reg <= w_next;
        r_reg <= r_next;
    end

    assert property (@(posedge clk) disable iff (!rst_n)
        cmd.start_block |=> round_reg == 6'd0)
        else $error("round counter not cleared at block start");
    assert property (@(posedge clk) disable iff (!rst_n)
        cmd.reset_hash |=> fill_reg == 6'd0 && total_reg == 64'd0)
        else $error("counters not cleared after digest");
endmodule

// ----- hw/rtl/sha_ctrl.sv -----
module sha_ctrl (
    input  logic clk,
    input  logic rst_n,
    sha_in_if.sink in_ch,
    input  logic out_ready,
    output logic out_valid,
    output logic [2:0] word_sel,
    input  sha_pkg::status_t status,
    output sha_pkg::cmd_t cmd
);
    sha_pkg::state_t state_reg, state_next;
    logic [5:0] cnt_reg, cnt_next;
    logic pad_reg, pad_next;   // padding run in progress
    logic len_blk_reg, len_blk_next;   // length bytes go into the current block
    logic [63:0] len_reg, len_next;
    logic [5:0] pos;

    assign word_sel = cnt_reg[2:0];
    assign pos = status.fill;

    always_comb
    begin
        state_next = state_reg;
        cnt_next = cnt_reg;
        pad_next = pad_reg;
        len_blk_next = len_blk_reg;
        len_next = len_reg;
        cmd = '0;
        in_ch.ready = 1'b0;
        out_valid = 1'b0;
        case (state_reg)
            sha_pkg::ST_IDLE:
            begin
                in_ch.ready = 1'b1;
                if (in_ch.valid)
                begin
                    if (!in_ch.kind)
                    begin
                        cmd.load_byte = 1'b1;
                        cmd.load_value = in_ch.data_byte;
                        cmd.count_byte = 1'b1;
                        if (pos == 6'd63)
                            state_next = sha_pkg::ST_ROUND;
                    end
                    else
                    begin
                        len_next = status.bit_len;
                        cmd.load_byte = 1'b1;
                        cmd.load_value = sha_pkg::PAD_BYTE;
                        pad_next = 1'b1;
                        // length fits after the pad only if the pad lands below byte 56
                        len_blk_next = (pos < sha_pkg::LEN_POS);
                        state_next = (pos == 6'd63) ? sha_pkg::ST_ROUND : sha_pkg::ST_PAD;
                    end
                    cmd.start_block = (pos == 6'd63);
                    cnt_next = '0;
                end
            end
            sha_pkg::ST_PAD:
            begin
                cmd.load_byte = 1'b1;
                if (len_blk_reg && pos >= sha_pkg::LEN_POS)
                    cmd.load_value = len_reg[{~pos[2:0], 3'b000} +: 8];
                else
                    cmd.load_value = 8'h00;
                if (pos == 6'd63)
                begin
                    cmd.start_block = 1'b1;
                    cnt_next = '0;
                    state_next = sha_pkg::ST_ROUND;
                end
            end
            sha_pkg::ST_ROUND:
            begin
                cmd.round_step = 1'b1;
                cnt_next = cnt_reg + 6'd1;
                if (cnt_reg == 6'd63)
                    state_next = sha_pkg::ST_ADD;
            end
            sha_pkg::ST_ADD:
            begin
                cmd.add_hash = 1'b1;
                cnt_next = '0;
                if (!pad_reg)
                    state_next = sha_pkg::ST_IDLE;
                else if (len_blk_reg)
                    state_next = sha_pkg::ST_EMIT;
                else
                begin
                    // no room was left for the length: zero fill a fresh block, length at its end
                    len_blk_next = 1'b1;
                    state_next = sha_pkg::ST_PAD;
                end
            end
            sha_pkg::ST_EMIT:
            begin
                out_valid = 1'b1;
                if (out_ready)
                begin
                    cnt_next = cnt_reg + 6'd1;
                    if (cnt_reg[2:0] == 3'd7)
                    begin
                        cmd.reset_hash = 1'b1;
                        pad_next = 1'b0;
                        state_next = sha_pkg::ST_IDLE;
                    end
                end
            end
            default: state_next = sha_pkg::ST_IDLE;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= sha_pkg::ST_IDLE;
            cnt_reg <= '0;
            pad_reg <= 1'b0;
            len_blk_reg <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            cnt_reg <= cnt_next;
            pad_reg <= pad_next;
            len_blk_reg <= len_blk_next;
        end
    end

    always_ff @(posedge clk)
    begin
        len_reg <= len_next;
    end

    assert property (@(posedge clk) disable iff (!rst_n)
        out_valid |-> state_reg == sha_pkg::ST_EMIT && pad_reg)
        else $error("digest shown outside emit");
    assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == sha_pkg::ST_ROUND && cnt_reg == 6'd63) |=> state_reg == sha_pkg::ST_ADD)
        else $error("round loop did not finish");
    assert property (@(posedge clk) disable iff (!rst_n)
        state_reg == sha_pkg::ST_EMIT |-> len_blk_reg)
        else $error("digest emitted before length block");
endmodule
